[rtl/assert_macros.svh]
// assertion macros, included by fpdp_back
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion label failed");

// condition that must never hold
`define ASSERT_NEVER(label, clk, rst, cond) \
   `ASSERT_CLK(label, clk, rst, !(cond))

`endif

[rtl/fpdp_pkg.sv]
// shared types and constants of the binary64 dot product
// no dependencies
package fpdp_pkg;

   localparam logic [63:0] CANON_NAN = 64'h7FF8000000000000;

   // adder result destinations
   localparam logic [2:0] DST_L0  = 3'd0;
   localparam logic [2:0] DST_L1  = 3'd1;
   localparam logic [2:0] DST_L2  = 3'd2;
   localparam logic [2:0] DST_L3  = 3'd3;
   localparam logic [2:0] DST_ACC = 3'd4;
   localparam logic [2:0] DST_TMP = 3'd5;

   typedef struct packed {
      logic [1:0] pos;
      logic       last;
   } item_tag_type;

   typedef struct packed {
      logic [63:0]  prod;
      item_tag_type tag;
   } q_entry_type;

endpackage

[rtl/fp64_dot_product.sv]
// Four-lane binary64 dot product. The front takes one element pair per
// cycle as long as queue credit lasts (QUEUE_DEPTH words between input and
// accumulator), multiplies it in an 8-stage pipeline and queues the product.
// The back adds each complete group of four into its lane through a shared
// 6-stage adder, issuing a new group before the sums of the last are back
// and stalling only on a lane still in flight. After the last element the
// reduction and the leftover products run as 3 to 6 dependent adds, and
// the sum waits in an output register while the next vector streams in.
// depends on fpdp_pkg, fpdp_front, fpdp_fifo and fpdp_back
module fp64_dot_product import fpdp_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // a_bits [63:0], b_bits [127:64]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // sum_bits [63:0]
   input  logic         csr_wen,
   input  logic         csr_wdata    // reduction_mode
);

   logic        mode_ff;
   logic        push, pop, q_valid;
   q_entry_type push_data, q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wen) begin
         mode_ff <= csr_wdata;
      end
   end

   fpdp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_a        (req_tdata[63:0]),
      .in_b        (req_tdata[127:64]),
      .in_last     (req_tlast),
      .q_pop       (pop),
      .q_push      (push),
      .q_push_data (push_data)
   );

   fpdp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   fpdp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/fpdp_mul.sv]
// pipelined binary64 multiplier, round to nearest even, subnormals kept
// depends on fpdp_pkg; carries an item tag alongside each product
module fpdp_mul import fpdp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [63:0]  in_a,
   input  logic [63:0]  in_b,
   input  item_tag_type in_tag,
   output logic         out_valid,
   output logic [63:0]  out_prod,
   output item_tag_type out_tag
);

   typedef struct packed {
      logic         valid;
      item_tag_type tag;
      logic         sign;
      logic         nan;
      logic         inf;
      logic         zero;
   } mctl_type;

   function automatic logic [6:0] lzc106(input logic [105:0] v);
      logic [6:0] n;
      n = 7'd106;
      for (int i = 0; i < 106; i++) begin
         if (v[i]) n = 7'(105 - i);
      end
      return n;
   endfunction

   // unpack
   logic [10:0] ea_raw, eb_raw, ea_eff, eb_eff;
   logic [52:0] a_man, b_man;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   mctl_type    ctl_in;
   logic [63:0] p1;

   assign ea_raw = in_a[62:52];
   assign eb_raw = in_b[62:52];
   assign ea_eff = (ea_raw == 11'd0) ? 11'd1 : ea_raw;
   assign eb_eff = (eb_raw == 11'd0) ? 11'd1 : eb_raw;
   assign a_man  = {ea_raw != 11'd0, in_a[51:0]};
   assign b_man  = {eb_raw != 11'd0, in_b[51:0]};
   assign a_nan  = (ea_raw == 11'h7FF) && (in_a[51:0] != 52'd0);
   assign b_nan  = (eb_raw == 11'h7FF) && (in_b[51:0] != 52'd0);
   assign a_inf  = (ea_raw == 11'h7FF) && (in_a[51:0] == 52'd0);
   assign b_inf  = (eb_raw == 11'h7FF) && (in_b[51:0] == 52'd0);
   assign a_zero = (ea_raw == 11'd0) && (in_a[51:0] == 52'd0);
   assign b_zero = (eb_raw == 11'd0) && (in_b[51:0] == 52'd0);

   always_comb begin
      ctl_in.valid = in_valid;
      ctl_in.tag   = in_tag;
      ctl_in.sign  = in_a[63] ^ in_b[63];
      ctl_in.nan   = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
      ctl_in.inf   = a_inf | b_inf;
      ctl_in.zero  = a_zero | b_zero;
   end

   assign p1 = a_man[31:0] * b_man[31:0];

   // stage 1: low partial product
   mctl_type    c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff, c7_ff, c8_ff;
   logic [63:0] r1_ff;
   logic [20:0] ahi1_ff, bhi1_ff, ahi2_ff, bhi2_ff, ahi3_ff, bhi3_ff;
   logic [31:0] alo1_ff, blo1_ff, blo2_ff;
   logic [10:0] ea1_ff, eb1_ff, ea2_ff, eb2_ff, ea3_ff, eb3_ff, ea4_ff, eb4_ff;

   // stage 2..4: remaining partial products accumulated
   logic [52:0]  p2, p3;
   logic [41:0]  p4;
   logic [105:0] sum2, sum3, sum4;
   logic [105:0] r2_ff, r3_ff, r4_ff;

   assign p2   = alo1_ff * bhi1_ff;
   assign sum2 = {42'd0, r1_ff} + {21'd0, p2, 32'd0};
   assign p3   = ahi2_ff * blo2_ff;
   assign sum3 = r2_ff + {21'd0, p3, 32'd0};
   assign p4   = ahi3_ff * bhi3_ff;
   assign sum4 = r3_ff + {p4, 64'd0};

   // stage 5: leading zero count and exponent
   logic [6:0]   lz5_in, lz5_ff;
   logic [12:0]  e5_in, e5_ff, e6_ff;
   logic [105:0] r5_ff, n6_ff;

   assign lz5_in = lzc106(r4_ff);
   assign e5_in  = {2'd0, ea4_ff} + {2'd0, eb4_ff} - 13'd1022 - {6'd0, lz5_in};

   // stage 7: subnormal alignment
   logic [12:0]  sh_full;
   logic [6:0]   sh7;
   logic [211:0] wide7;
   logic [105:0] n7_in, n7_ff;
   logic         lost7_in, lost7_ff, ovf7_in, ovf7_ff;
   logic [10:0]  field7_in, field7_ff;

   assign sh_full = 13'd1 - e6_ff;
   assign sh7     = (sh_full > 13'd127) ? 7'd127 : sh_full[6:0];
   assign wide7   = {n6_ff, 106'd0} >> sh7;

   always_comb begin
      if ($signed(e6_ff) < 13'sd1) begin
         n7_in     = wide7[211:106];
         lost7_in  = |wide7[105:0];
         field7_in = 11'd0;
         ovf7_in   = 1'b0;
      end else begin
         n7_in     = n6_ff;
         lost7_in  = 1'b0;
         field7_in = e6_ff[10:0];
         ovf7_in   = (e6_ff >= 13'd2047);
      end
   end

   // stage 8: round and pack
   logic [52:0] mant8;
   logic        guard8, sticky8, inc8;
   logic [62:0] packed8;
   logic [63:0] prod8_in, prod8_ff;

   assign mant8   = n7_ff[105:53];
   assign guard8  = n7_ff[52];
   assign sticky8 = (|n7_ff[51:0]) | lost7_ff;
   assign inc8    = guard8 & (sticky8 | mant8[0]);
   assign packed8 = {field7_ff, mant8[51:0]} + {62'd0, inc8};

   always_comb begin
      if (c7_ff.nan) begin
         prod8_in = CANON_NAN;
      end else if (c7_ff.inf || (ovf7_ff && !c7_ff.zero)) begin
         prod8_in = {c7_ff.sign, 11'h7FF, 52'd0};
      end else if (c7_ff.zero) begin
         prod8_in = {c7_ff.sign, 63'd0};
      end else begin
         prod8_in = {c7_ff.sign, packed8};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
         c7_ff <= '0;
         c8_ff <= '0;
      end else begin
         c1_ff <= ctl_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
         c5_ff <= c4_ff;
         c6_ff <= c5_ff;
         c7_ff <= c6_ff;
         c8_ff <= c7_ff;
      end
   end

   always_ff @(posedge clock) begin
      r1_ff     <= p1;
      ahi1_ff   <= a_man[52:32];
      bhi1_ff   <= b_man[52:32];
      alo1_ff   <= a_man[31:0];
      blo1_ff   <= b_man[31:0];
      ea1_ff    <= ea_eff;
      eb1_ff    <= eb_eff;
      r2_ff     <= sum2;
      ahi2_ff   <= ahi1_ff;
      bhi2_ff   <= bhi1_ff;
      blo2_ff   <= blo1_ff;
      ea2_ff    <= ea1_ff;
      eb2_ff    <= eb1_ff;
      r3_ff     <= sum3;
      ahi3_ff   <= ahi2_ff;
      bhi3_ff   <= bhi2_ff;
      ea3_ff    <= ea2_ff;
      eb3_ff    <= eb2_ff;
      r4_ff     <= sum4;
      ea4_ff    <= ea3_ff;
      eb4_ff    <= eb3_ff;
      r5_ff     <= r4_ff;
      lz5_ff    <= lz5_in;
      e5_ff     <= e5_in;
      n6_ff     <= r5_ff << lz5_ff;
      e6_ff     <= e5_ff;
      n7_ff     <= n7_in;
      lost7_ff  <= lost7_in;
      field7_ff <= field7_in;
      ovf7_ff   <= ovf7_in;
      prod8_ff  <= prod8_in;
   end

   assign out_valid = c8_ff.valid;
   assign out_tag   = c8_ff.tag;
   assign out_prod  = prod8_ff;

endmodule

[rtl/fpdp_add.sv]
// pipelined binary64 adder, round to nearest even, subnormals kept
// depends on fpdp_pkg; carries a destination code alongside each sum
module fpdp_add import fpdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_x,
   input  logic [63:0] in_y,
   input  logic [2:0]  in_dst,
   output logic        out_valid,
   output logic [63:0] out_sum,
   output logic [2:0]  out_dst
);

   typedef struct packed {
      logic       valid;
      logic [2:0] dst;
      logic       nan;
      logic       inf;
      logic       sign;
      logic       zsign;
      logic       sub;
   } actl_type;

   function automatic logic [5:0] lzc56(input logic [55:0] v);
      logic [5:0] n;
      n = 6'd56;
      for (int i = 0; i < 56; i++) begin
         if (v[i]) n = 6'(55 - i);
      end
      return n;
   endfunction

   // stage 1: classify and order by magnitude
   logic        swap;
   logic [63:0] big, sml;
   logic [10:0] eb_raw, es_raw, eb_eff, es_eff;
   logic        x_nan, y_nan, x_inf, y_inf;
   actl_type    ctl_in;

   assign swap   = in_y[62:0] > in_x[62:0];
   assign big    = swap ? in_y : in_x;
   assign sml    = swap ? in_x : in_y;
   assign eb_raw = big[62:52];
   assign es_raw = sml[62:52];
   assign eb_eff = (eb_raw == 11'd0) ? 11'd1 : eb_raw;
   assign es_eff = (es_raw == 11'd0) ? 11'd1 : es_raw;
   assign x_nan  = (in_x[62:52] == 11'h7FF) && (in_x[51:0] != 52'd0);
   assign y_nan  = (in_y[62:52] == 11'h7FF) && (in_y[51:0] != 52'd0);
   assign x_inf  = (in_x[62:52] == 11'h7FF) && (in_x[51:0] == 52'd0);
   assign y_inf  = (in_y[62:52] == 11'h7FF) && (in_y[51:0] == 52'd0);

   always_comb begin
      ctl_in.valid = in_valid;
      ctl_in.dst   = in_dst;
      ctl_in.nan   = x_nan | y_nan | (x_inf & y_inf & (in_x[63] ^ in_y[63]));
      ctl_in.inf   = x_inf | y_inf;
      ctl_in.sign  = big[63];
      ctl_in.zsign = in_x[63] & in_y[63];
      ctl_in.sub   = in_x[63] ^ in_y[63];
   end

   actl_type    c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic [52:0] mb1_ff, ms1_ff;
   logic [10:0] e1_ff, d1_ff, e2_ff, e3_ff, e4_ff;

   // stage 2: align the smaller operand, sticky in the lowest bit
   logic [111:0] wide2;
   logic [55:0]  ws2_in, ws2_ff, wb2_ff;

   assign wide2 = {ms1_ff, 3'd0, 56'd0} >> d1_ff[5:0];

   always_comb begin
      if (d1_ff >= 11'd56) begin
         ws2_in = {55'd0, |ms1_ff};
      end else begin
         ws2_in = wide2[111:56] | {55'd0, |wide2[55:0]};
      end
   end

   // stage 3: add or subtract magnitudes
   logic [56:0] s3_in, s3_ff, s4_ff;

   assign s3_in = c2_ff.sub ? ({1'b0, wb2_ff} - {1'b0, ws2_ff})
                            : ({1'b0, wb2_ff} + {1'b0, ws2_ff});

   // stage 4: leading zeros
   logic [5:0] lz4_ff;

   // stage 5: normalize, stopping at the subnormal boundary
   logic [10:0] lim5;
   logic [5:0]  sh5;
   logic [55:0] shl5, t5_in, t5_ff;
   logic [11:0] fe5_in, fe5_ff;
   logic        z5_in, z5_ff;

   assign lim5 = e4_ff - 11'd1;
   assign sh5  = ({5'd0, lz4_ff} < lim5) ? lz4_ff : lim5[5:0];
   assign shl5 = s4_ff[55:0] << sh5;

   always_comb begin
      z5_in = (s4_ff == 57'd0);
      if (s4_ff[56]) begin
         t5_in  = s4_ff[56:1] | {55'd0, s4_ff[0]};
         fe5_in = {1'b0, e4_ff} + 12'd1;
      end else begin
         t5_in  = shl5;
         fe5_in = shl5[55] ? ({1'b0, e4_ff} - {6'd0, sh5}) : 12'd0;
      end
   end

   // stage 6: round and pack
   logic [52:0] mant6;
   logic        inc6;
   logic [62:0] packed6;
   logic [63:0] sum6_in, sum6_ff;

   assign mant6   = t5_ff[55:3];
   assign inc6    = t5_ff[2] & (t5_ff[1] | t5_ff[0] | mant6[0]);
   assign packed6 = {fe5_ff[10:0], mant6[51:0]} + {62'd0, inc6};

   always_comb begin
      if (c5_ff.nan) begin
         sum6_in = CANON_NAN;
      end else if (c5_ff.inf) begin
         sum6_in = {c5_ff.sign, 11'h7FF, 52'd0};
      end else if (z5_ff) begin
         sum6_in = {c5_ff.zsign, 63'd0};
      end else if (fe5_ff >= 12'd2047) begin
         sum6_in = {c5_ff.sign, 11'h7FF, 52'd0};
      end else begin
         sum6_in = {c5_ff.sign, packed6};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else begin
         c1_ff <= ctl_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
         c5_ff <= c4_ff;
         c6_ff <= c5_ff;
      end
   end

   always_ff @(posedge clock) begin
      mb1_ff  <= {eb_raw != 11'd0, big[51:0]};
      ms1_ff  <= {es_raw != 11'd0, sml[51:0]};
      e1_ff   <= eb_eff;
      d1_ff   <= eb_eff - es_eff;
      wb2_ff  <= {mb1_ff, 3'd0};
      ws2_ff  <= ws2_in;
      e2_ff   <= e1_ff;
      s3_ff   <= s3_in;
      e3_ff   <= e2_ff;
      s4_ff   <= s3_ff;
      lz4_ff  <= lzc56(s3_ff[55:0]);
      e4_ff   <= e3_ff;
      t5_ff   <= t5_in;
      fe5_ff  <= fe5_in;
      z5_ff   <= z5_in;
      sum6_ff <= sum6_in;
   end

   assign out_valid = c6_ff.valid;
   assign out_dst   = c6_ff.dst;
   assign out_sum   = sum6_ff;

endmodule

[rtl/fpdp_fifo.sv]
// product queue between the multiplier front and the accumulator back
// depends on fpdp_pkg for the entry type
module fpdp_fifo import fpdp_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_data,
   input  logic        pop,
   output logic        out_valid,
   output q_entry_type out_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   q_entry_type   mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign out_valid = (count_ff != CW'(0));
   assign out_data  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/fpdp_front.sv]
// front end: accepts element pairs, tags group position, runs the multiplier
// depends on fpdp_pkg and fpdp_mul; queue space is reserved by credit
module fpdp_front import fpdp_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [63:0]  in_a,
   input  logic [63:0]  in_b,
   input  logic         in_last,
   input  logic         q_pop,
   output logic         q_push,
   output q_entry_type  q_push_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [CW-1:0] credit_ff, credit_in;
   logic [1:0]    pos_ff, pos_in;
   logic          accept;
   item_tag_type  tag;
   logic          mul_valid;
   logic [63:0]   mul_prod;
   item_tag_type  mul_tag;

   // words in the multiplier plus words in the queue
   assign in_ready = (credit_ff < CW'(QUEUE_DEPTH));
   assign accept   = in_valid && in_ready;

   always_comb begin
      tag.pos  = pos_ff;
      tag.last = in_last;
      pos_in   = pos_ff;
      if (accept) begin
         pos_in = in_last ? 2'd0 : pos_ff + 2'd1;
      end
      case ({accept, q_pop})
         2'b10:   credit_in = credit_ff + CW'(1);
         2'b01:   credit_in = credit_ff - CW'(1);
         default: credit_in = credit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         pos_ff    <= '0;
      end else begin
         credit_ff <= credit_in;
         pos_ff    <= pos_in;
      end
   end

   fpdp_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_a      (in_a),
      .in_b      (in_b),
      .in_tag    (tag),
      .out_valid (mul_valid),
      .out_prod  (mul_prod),
      .out_tag   (mul_tag)
   );

   assign q_push           = mul_valid;
   assign q_push_data.prod = mul_prod;
   assign q_push_data.tag  = mul_tag;

endmodule

[rtl/fpdp_back.sv]
// back end: lane accumulation, reduction, tail sum and result register
// depends on fpdp_pkg, fpdp_add and assert_macros.svh
`include "assert_macros.svh"
module fpdp_back import fpdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        mode,
   input  logic        q_valid,
   input  q_entry_type q_data,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LANE = 3'd1;
   localparam logic [2:0] ST_RED  = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [63:0] lane_ff [4];
   logic [63:0] lane_in [4];
   logic [63:0] held_ff [3];
   logic [63:0] held_in [3];
   logic [63:0] prod3_ff, prod3_in, acc_ff, acc_in, tmp_ff, tmp_in;
   logic [3:0]  busy_ff, busy_in, busy_set, busy_clr;
   logic [1:0]  kidx_ff, kidx_in, pos_ff, pos_in, held_idx;
   logic        last_ff, last_in;
   logic [2:0]  step_ff, step_in, step_next;
   logic        step_end;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;
   logic [63:0] held_sel;

   logic        add_valid;
   logic [63:0] add_x, add_y;
   logic [2:0]  add_dst;
   logic        add_out_valid;
   logic [63:0] add_out_sum;
   logic [2:0]  add_out_dst;

   fpdp_add u_add (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (add_valid),
      .in_x      (add_x),
      .in_y      (add_y),
      .in_dst    (add_dst),
      .out_valid (add_out_valid),
      .out_sum   (add_out_sum),
      .out_dst   (add_out_dst)
   );

   assign step_next = step_ff + 3'd1;
   assign step_end  = (pos_ff == 2'd3) ? (step_next == 3'd3)
                                       : (step_next == ({1'b0, pos_ff} + 3'd4));
   // one read port on the held products: lane issue or tail step
   assign held_idx  = (state_ff == ST_LANE) ? kidx_ff : 2'(step_ff - 3'd3);

   always_comb begin
      case (held_idx)
         2'd0:    held_sel = held_ff[0];
         2'd1:    held_sel = held_ff[1];
         2'd2:    held_sel = held_ff[2];
         default: held_sel = prod3_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      lane_in      = lane_ff;
      held_in      = held_ff;
      prod3_in     = prod3_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      kidx_in      = kidx_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      busy_set     = 4'd0;
      busy_clr     = 4'd0;
      add_valid    = 1'b0;
      add_x        = 64'd0;
      add_y        = 64'd0;
      add_dst      = DST_ACC;
      q_pop        = 1'b0;

      // adder write back
      if (add_out_valid) begin
         case (add_out_dst)
            DST_L0, DST_L1, DST_L2, DST_L3: begin
               lane_in[add_out_dst[1:0]]  = add_out_sum;
               busy_clr[add_out_dst[1:0]] = 1'b1;
            end
            DST_ACC: acc_in = add_out_sum;
            DST_TMP: tmp_in = add_out_sum;
            default: ;
         endcase
      end

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_data.tag.pos != 2'd3) begin
                  held_in[q_data.tag.pos] = q_data.prod;
                  if (q_data.tag.last) begin
                     pos_in   = q_data.tag.pos;
                     step_in  = 3'd0;
                     state_in = ST_RED;
                  end
               end else begin
                  prod3_in = q_data.prod;
                  kidx_in  = 2'd0;
                  last_in  = q_data.tag.last;
                  pos_in   = 2'd3;
                  state_in = ST_LANE;
               end
            end
         end
         ST_LANE: begin
            if (!busy_ff[kidx_ff]) begin
               add_valid         = 1'b1;
               add_x             = lane_ff[kidx_ff];
               add_y             = held_sel;
               add_dst           = DST_L0 | {1'b0, kidx_ff};
               busy_set[kidx_ff] = 1'b1;
               kidx_in           = kidx_ff + 2'd1;
               if (kidx_ff == 2'd3) begin
                  step_in  = 3'd0;
                  state_in = last_ff ? ST_RED : ST_IDLE;
               end
            end
         end
         ST_RED: begin
            // the first reduction step waits for the lanes to settle
            if (step_ff != 3'd0 || busy_ff == 4'd0) begin
               add_valid = 1'b1;
               state_in  = ST_WAIT;
               case (step_ff)
                  3'd0: begin
                     add_x   = lane_ff[0];
                     add_y   = mode ? lane_ff[2] : lane_ff[1];
                     add_dst = DST_ACC;
                  end
                  3'd1: begin
                     add_x   = mode ? lane_ff[1] : acc_ff;
                     add_y   = mode ? lane_ff[3] : lane_ff[2];
                     add_dst = mode ? DST_TMP : DST_ACC;
                  end
                  3'd2: begin
                     add_x   = acc_ff;
                     add_y   = mode ? tmp_ff : lane_ff[3];
                     add_dst = DST_ACC;
                  end
                  default: begin
                     add_x   = acc_ff;
                     add_y   = held_sel;
                     add_dst = DST_ACC;
                  end
               endcase
            end
         end
         ST_WAIT: begin
            if (add_out_valid && (add_out_dst == DST_ACC || add_out_dst == DST_TMP)) begin
               step_in  = step_next;
               state_in = step_end ? ST_OUT : ST_RED;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               if (acc_ff[62:52] == 11'h7FF && acc_ff[51:0] != 52'd0) begin
                  out_data_in = CANON_NAN;
               end else begin
                  out_data_in = acc_ff;
               end
               for (int i = 0; i < 4; i++) begin
                  lane_in[i] = 64'd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      busy_in = (busy_ff & ~busy_clr) | busy_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 4'd0;
         kidx_ff      <= 2'd0;
         step_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            lane_ff[i] <= 64'd0;
         end
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         kidx_ff      <= kidx_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
         lane_ff      <= lane_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      prod3_ff    <= prod3_in;
      acc_ff      <= acc_in;
      tmp_ff      <= tmp_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `ASSERT_NEVER(a_issue_busy_lane, clock, reset, add_valid && add_dst <= DST_L3 && busy_ff[add_dst[1:0]])
   `ASSERT_CLK(a_lane_wb_was_busy, clock, reset, (add_out_valid && add_out_dst <= DST_L3) |-> busy_ff[add_out_dst[1:0]])
   `ASSERT_CLK(a_reduce_lanes_idle, clock, reset, (state_ff == ST_WAIT) |-> (busy_ff == 4'd0))
   `ASSERT_CLK(a_result_held, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))

endmodule

[bench/fp64_dot_product_tb.sv]
// testbench for the four-lane binary64 dot product: directed table, then random vectors
// under both reduction modes, each sum checked against a typed sum or an in-bench accumulator model
// depends on fpdp_pkg and fp64_dot_product
module fp64_dot_product_tb;
   import fpdp_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 100;
   localparam bit MODE_SEQ = 1'b0;
   localparam bit MODE_PAIR = 1'b1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         csr_wen = 1'b0;
   logic         csr_wdata = 1'b0;

   fp64_dot_product uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   typedef struct {
      logic [63:0] a;
      logic [63:0] b;
      logic        last;
      logic        typed;
      logic [63:0] sum;
   } pair_row_type;

   // accumulator model state
   real      lane_acc[4];
   real      held_prod[3];
   int       group_pos;
   bit       reduce_mode;

   logic [63:0] sum_q[$];      // sums still to arrive
   logic        typed_q[$];    // per driven word: sum typed in by the table
   logic [63:0] typed_sum_q[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          sender_gap_pct = 40;

   function automatic logic [63:0] accumulate_pair(logic [63:0] a, logic [63:0] b,
                                                   logic last, output bit done);
      real prod, total;
      logic [63:0] bits;
      prod = $bitstoreal(a) * $bitstoreal(b);
      done = 1'b0;
      bits = '0;
      if (group_pos == 3) begin
         for (int i = 0; i < 3; i++) lane_acc[i] = lane_acc[i] + held_prod[i];
         lane_acc[3] = lane_acc[3] + prod;
      end else begin
         held_prod[group_pos] = prod;
      end
      if (!last) begin
         group_pos = (group_pos + 1) % 4;
      end else begin
         if (reduce_mode == MODE_PAIR)
            total = (lane_acc[0] + lane_acc[2]) + (lane_acc[1] + lane_acc[3]);
         else
            total = ((lane_acc[0] + lane_acc[1]) + lane_acc[2]) + lane_acc[3];
         // leftover products of a partial group, in element order
         if (group_pos != 3)
            for (int i = 0; i <= group_pos; i++) total = total + held_prod[i];
         bits = $realtobits(total);
         if (bits[62:52] == 11'h7FF && bits[51:0] != 0) bits = CANON_NAN;
         for (int i = 0; i < 4; i++) lane_acc[i] = 0.0;
         group_pos = 0;
         done = 1'b1;
      end
      return bits;
   endfunction

   // samples pre-edge values, so driver updates in the same step do not race
   always @(posedge clock) begin
      bit done;
      logic [63:0] s;
      logic typed;
      logic [63:0] tsum;
      cycles <= cycles + 1;
      if (reset) begin
         for (int i = 0; i < 4; i++) lane_acc[i] = 0.0;
         for (int i = 0; i < 3; i++) held_prod[i] = 0.0;
         group_pos = 0;
         reduce_mode = MODE_SEQ;
      end else begin
         if (csr_wen) reduce_mode = csr_wdata;
         if (req_tvalid && req_tready) begin
            typed = typed_q.pop_front();
            tsum = typed_sum_q.pop_front();
            s = accumulate_pair(req_tdata[63:0], req_tdata[127:64], req_tlast, done);
            if (done) sum_q.push_back(typed ? tsum : s);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (sum_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word on rsp: %h", rsp_tdata);
            end else begin
               s = sum_q.pop_front();
               if (rsp_tdata !== s) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("sum_bits mismatch: expected %h got %h", s, rsp_tdata);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side stalls: phases of none, light and heavy, plus rare long holds
   initial begin
      int pct;
      pct = 0;
      forever begin
         @(posedge clock);
         if (cycles % 300 == 0) pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
         if (pct != 0 && $urandom_range(0, 499) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= pct);
      end
   end

   task automatic send_word(logic [63:0] a, logic [63:0] b, logic last,
                            logic typed, logic [63:0] tsum);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      gap = 0;
      if (r < sender_gap_pct) gap = (r < sender_gap_pct - 5) ? $urandom_range(1, 3)
                                                            : $urandom_range(10, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, a};
      req_tlast <= last;
      typed_q.push_back(typed);
      typed_sum_q.push_back(tsum);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      // let the monitor log the sum of a word accepted at this edge
      @(posedge clock);
      while (sum_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(bit m);
      wait_drained();
      csr_wen <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [63:0] random_double();
      int r;
      logic [63:0] v;
      logic [63:0] specials[9] = '{64'h0, 64'h7FF0000000000000, 64'h7FF8000000000000,
         64'h7FF0000000000001, 64'h1, 64'h000FFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF,
         64'h0010000000000000, 64'h3FF0000000000000};
      r = $urandom_range(0, 99);
      if (r < 60) begin
         v = {$urandom, $urandom};
         v[62:52] = 11'(1003 + $urandom_range(0, 40));
      end else if (r < 80) begin
         v = {$urandom, $urandom};
      end else begin
         v = specials[$urandom_range(0, 8)];
         v[63] = 1'($urandom_range(0, 1));
      end
      return v;
   endfunction

   pair_row_type pair_table[] = '{
      '{64'h3FF0000000000000, 64'h4000000000000000, 1'b1, 1'b1, 64'h4000000000000000},
      '{64'h7FF0000000000001, 64'h3FF0000000000000, 1'b1, 1'b1, CANON_NAN},
      '{64'h7FF0000000000000, 64'h0000000000000000, 1'b1, 1'b1, CANON_NAN},
      '{64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b1, CANON_NAN},
      '{64'h7FEFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 1'b1, 1'b1, 64'h7FF0000000000000},
      '{64'h0000000000000001, 64'h3FE0000000000000, 1'b1, 1'b1, 64'h0},
      '{64'h0000000000000001, 64'h3FF0000000000000, 1'b1, 1'b1, 64'h1},
      '{64'h8000000000000000, 64'h0000000000000000, 1'b1, 1'b1, 64'h0},
      '{64'h0000000000000000, 64'h0000000000000000, 1'b1, 1'b1, 64'h0},
      // complete final group
      '{64'h3FF0000000000000, 64'h3FF8000000000000, 1'b0, 1'b0, 64'h0},
      '{64'h4000000000000000, 64'hC000000000000000, 1'b0, 1'b0, 64'h0},
      '{64'h3CB0000000000000, 64'h3FF0000000000000, 1'b0, 1'b0, 64'h0},
      '{64'h4340000000000000, 64'h3FF0000000000000, 1'b1, 1'b0, 64'h0},
      // five elements, one leftover
      '{64'h3FF0000000000000, 64'h3FF0000000000000, 1'b0, 1'b0, 64'h0},
      '{64'h3CA0000000000000, 64'h3FF0000000000000, 1'b0, 1'b0, 64'h0},
      '{64'hBFF0000000000000, 64'h3FF0000000000000, 1'b0, 1'b0, 64'h0},
      '{64'h000FFFFFFFFFFFFF, 64'h4000000000000000, 1'b0, 1'b0, 64'h0},
      '{64'h4330000000000000, 64'h3FE0000000000000, 1'b1, 1'b0, 64'h0},
      // three elements, partial group only
      '{64'hBFF0000000000000, 64'h7FEFFFFFFFFFFFFF, 1'b0, 1'b0, 64'h0},
      '{64'h3FF0000000000000, 64'h7FEFFFFFFFFFFFFF, 1'b0, 1'b0, 64'h0},
      '{64'h0000000000000001, 64'hBFF0000000000000, 1'b1, 1'b0, 64'h0}
   };

   initial begin
      int n;
      int len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(MODE_SEQ);
      foreach (pair_table[i])
         send_word(pair_table[i].a, pair_table[i].b, pair_table[i].last,
                   pair_table[i].typed, pair_table[i].sum);
      for (int ph = 0; ph < 4; ph++) begin
         // sender waits for every outstanding sum before each mode change
         write_mode(ph % 2 == 0 ? MODE_PAIR : MODE_SEQ);
         n = 0;
         while (n < 380) begin
            sender_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 9) : $urandom_range(10, 40);
            for (int k = 0; k < len; k++)
               send_word(random_double(), random_double(), k == len - 1, 1'b0, 64'h0);
            n += len;
         end
      end
      wait_drained();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/fpdp_pkg.sv
rtl/fpdp_mul.sv
rtl/fpdp_add.sv
rtl/fpdp_fifo.sv
rtl/fpdp_front.sv
rtl/fpdp_back.sv
rtl/fp64_dot_product.sv
bench/fp64_dot_product_tb.sv
